// File: sv/icmp_probe_reply_classifier_assert.svh
// Assertion macros for the probe reply classifier.
`ifndef ICMP_PROBE_REPLY_CLASSIFIER_ASSERT_SVH
`define ICMP_PROBE_REPLY_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF
`define IPRC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("iprc assertion failed");
`define IPRC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("iprc assertion failed");
`else
`define IPRC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define IPRC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// File: sv/iprc_pkg.sv
package iprc_pkg;

  localparam int MaxPacketBytes = 2048;

  localparam int IdxW = 12;
  localparam logic [IdxW-1:0] IdxMax = '1;

  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
  localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
  localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
  localparam logic [7:0] PROTO_UDP          = 8'd17;
  localparam logic [7:0] ICMP_HEAD_LEN      = 8'd8;
  localparam logic [7:0] IP_MIN_HDR_LEN     = 8'd20;

  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_EXCEEDED = 2'd1;
  localparam logic [1:0] VERDICT_REACHED  = 2'd2;
  localparam logic [1:0] VERDICT_UNREACH  = 2'd3;

  localparam logic [1:0] REG_SOURCE_PORT    = 2'd0;
  localparam logic [1:0] REG_DEST_PORT_BASE = 2'd1;
  localparam logic [1:0] REG_PROBE_SEQUENCE = 2'd2;

  localparam logic [15:0] DEST_PORT_BASE_RST = 16'd33434;
  localparam logic [15:0] PROBE_SEQUENCE_RST = 16'd1;

  typedef struct packed {
    logic [IdxW-1:0] len;
    logic [5:0]      outer_hdr;
    logic [5:0]      inner_hdr;
    logic [7:0]      inner_proto;
    logic [7:0]      msg_type;
    logic [7:0]      msg_code;
    logic [15:0]     sport;
    logic [15:0]     dport;
  } capture_t;

  typedef struct packed {
    logic [15:0] source_port;
    logic [15:0] dest_port_base;
    logic [15:0] probe_sequence;
  } cfg_t;

endpackage

// File: sv/iprc_capture.sv
module iprc_capture #(
  parameter int MAX_PACKET_BYTES = iprc_pkg::MaxPacketBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output iprc_pkg::capture_t  cap_o
);

  localparam int IdxW = iprc_pkg::IdxW;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [5:0]      outer_q, outer_d;
  logic [5:0]      inner_q, inner_d;
  logic [7:0]      proto_q, proto_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      code_q, code_d;
  logic [15:0]     sport_q, sport_d;
  logic [15:0]     dport_q, dport_d;

  logic            in_range;
  logic [IdxW-1:0] type_pos, inner_pos, ports_pos;

  always_comb begin
    in_range = (32'(idx_q) < MAX_PACKET_BYTES);

    outer_d = outer_q;
    if (in_range && idx_q == '0) begin
      outer_d = {byte_i[3:0], 2'b00};
    end
    type_pos = IdxW'(outer_d);
    type_d = type_q;
    code_d = code_q;
    if (in_range && idx_q == type_pos) type_d = byte_i;
    if (in_range && idx_q == type_pos + IdxW'(1)) code_d = byte_i;

    inner_pos = type_pos + IdxW'(iprc_pkg::ICMP_HEAD_LEN);
    inner_d = inner_q;
    if (in_range && idx_q == inner_pos) begin
      inner_d = {byte_i[3:0], 2'b00};
    end
    proto_d = proto_q;
    if (in_range && idx_q == inner_pos + IdxW'(9)) proto_d = byte_i;

    ports_pos = inner_pos + IdxW'(inner_d);
    sport_d = sport_q;
    dport_d = dport_q;
    if (in_range && idx_q == ports_pos)             sport_d[15:8] = byte_i;
    if (in_range && idx_q == ports_pos + IdxW'(1))  sport_d[7:0]  = byte_i;
    if (in_range && idx_q == ports_pos + IdxW'(2))  dport_d[15:8] = byte_i;
    if (in_range && idx_q == ports_pos + IdxW'(3))  dport_d[7:0]  = byte_i;

    idx_d = (idx_q == iprc_pkg::IdxMax) ? idx_q : idx_q + IdxW'(1);

    cap_o.len = (32'(idx_d) > MAX_PACKET_BYTES) ? IdxW'(MAX_PACKET_BYTES) : idx_d;
    cap_o.outer_hdr   = outer_d;
    cap_o.inner_hdr   = inner_d;
    cap_o.inner_proto = proto_d;
    cap_o.msg_type    = type_d;
    cap_o.msg_code    = code_d;
    cap_o.sport       = sport_d;
    cap_o.dport       = dport_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      outer_q <= '0;
      inner_q <= '0;
      proto_q <= '0;
      type_q  <= '0;
      code_q  <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        idx_q   <= '0;
        outer_q <= '0;
        inner_q <= '0;
        proto_q <= '0;
        type_q  <= '0;
        code_q  <= '0;
        sport_q <= '0;
        dport_q <= '0;
      end else begin
        idx_q   <= idx_d;
        outer_q <= outer_d;
        inner_q <= inner_d;
        proto_q <= proto_d;
        type_q  <= type_d;
        code_q  <= code_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule

// File: sv/iprc_classify.sv
module iprc_classify (
  input  iprc_pkg::capture_t cap_i,
  input  iprc_pkg::cfg_t     cfg_i,
  output logic [1:0]         verdict_o
);

  localparam int IdxW = iprc_pkg::IdxW;

  logic [IdxW:0]   hdr_end;
  logic [IdxW-1:0] icmplen;
  logic [IdxW:0]   need_len;
  logic [15:0]     want_dport;
  logic            quoted_ok;
  logic            match;

  always_comb begin
    hdr_end    = (IdxW+1)'(cap_i.outer_hdr) + (IdxW+1)'(iprc_pkg::ICMP_HEAD_LEN);
    icmplen    = cap_i.len - IdxW'(cap_i.outer_hdr);
    need_len   = (IdxW+1)'(cap_i.inner_hdr) + (IdxW+1)'(iprc_pkg::ICMP_HEAD_LEN)
               + (IdxW+1)'(4);
    quoted_ok  = (icmplen >= IdxW'(iprc_pkg::ICMP_HEAD_LEN)
                            + IdxW'(iprc_pkg::IP_MIN_HDR_LEN))
              && ((IdxW+1)'(icmplen) >= need_len);
    want_dport = cfg_i.dest_port_base + cfg_i.probe_sequence;
    match      = quoted_ok && cap_i.inner_proto == iprc_pkg::PROTO_UDP
              && cap_i.sport == cfg_i.source_port && cap_i.dport == want_dport;

    verdict_o = iprc_pkg::VERDICT_NONE;
    if ((IdxW+1)'(cap_i.len) < hdr_end) begin
      verdict_o = iprc_pkg::VERDICT_NONE;
    end else if (cap_i.msg_type == iprc_pkg::TYPE_TIME_EXCEEDED
                 && cap_i.msg_code == iprc_pkg::CODE_IN_TRANSIT) begin
      verdict_o = match ? iprc_pkg::VERDICT_EXCEEDED : iprc_pkg::VERDICT_NONE;
    end else if (cap_i.msg_type == iprc_pkg::TYPE_UNREACHABLE && match) begin
      verdict_o = (cap_i.msg_code == iprc_pkg::CODE_PORT_UNREACH)
                ? iprc_pkg::VERDICT_REACHED : iprc_pkg::VERDICT_UNREACH;
    end
  end

endmodule

// File: sv/icmp_probe_reply_classifier.sv
// A last byte's verdict reaches m_axis via the input register and then the output register.
// Throughput: one packet byte per cycle; the input register stalls only when
// a last byte meets a verdict that is still held while m_axis_tready is low.
// Reset: asynchronous, active low; clears packet state, both pipeline valid
// flags and the config registers (source 0, port base 33434, sequence 1).
module icmp_probe_reply_classifier #(
  parameter int MAX_PACKET_BYTES = iprc_pkg::MaxPacketBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // packet_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // verdict[1:0], reply_code[9:2], reply_type[17:10], zeros
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  iprc_pkg::cfg_t     cfg_q;
  iprc_pkg::capture_t cap;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic [1:0] verdict;

  logic        out_valid_q;
  logic [17:0] out_data_q;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_port    <= '0;
      cfg_q.dest_port_base <= iprc_pkg::DEST_PORT_BASE_RST;
      cfg_q.probe_sequence <= iprc_pkg::PROBE_SEQUENCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iprc_pkg::REG_SOURCE_PORT:    cfg_q.source_port    <= cfg_wdata_i;
        iprc_pkg::REG_DEST_PORT_BASE: cfg_q.dest_port_base <= cfg_wdata_i;
        iprc_pkg::REG_PROBE_SEQUENCE: cfg_q.probe_sequence <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  iprc_capture #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cap_o  (cap)
  );

  iprc_classify u_classify (
    .cap_i     (cap),
    .cfg_i     (cfg_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= {cap.msg_type, cap.msg_code, verdict};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

`include "icmp_probe_reply_classifier_assert.svh"

  `IPRC_ASSERT_IMPL(a_mid_byte_flows, clk_i, rst_ni, in_valid_q && !in_last_q, advance)
  `IPRC_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, advance && in_last_q, m_axis_tvalid)
  `IPRC_ASSERT_IMPL(a_reached_is_unreach, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] == iprc_pkg::VERDICT_REACHED,
    m_axis_tdata[17:10] == iprc_pkg::TYPE_UNREACHABLE
    && m_axis_tdata[9:2] == iprc_pkg::CODE_PORT_UNREACH)
  `IPRC_ASSERT_IMPL(a_exceeded_type, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] == iprc_pkg::VERDICT_EXCEEDED,
    m_axis_tdata[17:10] == iprc_pkg::TYPE_TIME_EXCEEDED
    && m_axis_tdata[9:2] == iprc_pkg::CODE_IN_TRANSIT)

endmodule
